@@ sv/wbdc_pkg.sv @@
// Shared types and constants for the wheel balance drive controller.
`timescale 1ns / 1ps

package wbdc_pkg;

  localparam int unsigned TargetW = 16;
  localparam int unsigned PowerW  = 8;
  localparam int unsigned GainW   = 8;
  localparam int unsigned LcountW = 8;
  localparam int unsigned RcountW = 16;
  localparam int unsigned DeltaW  = GainW + RcountW;

  localparam logic [PowerW-1:0]  PowerMax      = '1;
  localparam logic [PowerW-1:0]  BasePowerRst  = 8'd100;
  localparam logic [GainW-1:0]   StepGainRst   = 8'd10;
  localparam logic [RcountW-1:0] RightMinLead  = 16'd2;

  localparam int unsigned AddrW = 4;
  localparam logic [AddrW-1:0] AddrTarget = 4'h0;
  localparam logic [AddrW-1:0] AddrBase   = 4'h4;
  localparam logic [AddrW-1:0] AddrGain   = 4'h8;

  typedef enum logic {
    CMD_START  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [TargetW-1:0] target_pulses;
    logic [PowerW-1:0]  base_power;
    logic [GainW-1:0]   step_gain;
  } cfg_t;

  typedef struct packed {
    logic [PowerW-1:0] left_hold;
    logic [PowerW-1:0] right_hold;
    logic              left_finished;
    logic              right_finished;
    logic [PowerW-1:0] left_ramp;
    logic [PowerW-1:0] right_ramp;
    logic              active;
  } state_t;

  typedef struct packed {
    cmd_e               command;
    logic [LcountW-1:0] left_count;
    logic [RcountW-1:0] right_count;
  } req_t;

  typedef struct packed {
    logic [PowerW-1:0] left_drive;
    logic [PowerW-1:0] right_drive;
    logic              left_at_target;
    logic              right_at_target;
    logic              moving;
    logic              move_done;
  } res_t;

endpackage

@@ sv/wbdc_regs.sv @@
// APB configuration registers of the wheel balance drive controller.
`timescale 1ns / 1ps

module wbdc_regs
  import wbdc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr)
        AddrTarget: cfg_d.target_pulses = pwdata[TargetW-1:0];
        AddrBase:   cfg_d.base_power    = pwdata[PowerW-1:0];
        AddrGain:   cfg_d.step_gain     = pwdata[GainW-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_pulses <= '0;
      cfg_q.base_power    <= BasePowerRst;
      cfg_q.step_gain     <= StepGainRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (paddr)
      AddrTarget: prdata = {{(32-TargetW){1'b0}}, cfg_q.target_pulses};
      AddrBase:   prdata = {{(32-PowerW){1'b0}}, cfg_q.base_power};
      AddrGain:   prdata = {{(32-GainW){1'b0}}, cfg_q.step_gain};
      default:    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/wbdc_step.sv @@
// Per-request update of the drive state and the result fields.
`timescale 1ns / 1ps

module wbdc_step
  import wbdc_pkg::*;
(
  input  cfg_t   cfg_i,
  input  state_t state_i,
  input  req_t   req_i,
  output state_t state_o,
  output res_t   res_o
);

  logic [RcountW-1:0] lc_ext;
  logic [RcountW-1:0] diff;
  logic [DeltaW-1:0]  delta;
  logic [DeltaW:0]    sum;
  logic [PowerW-1:0]  pw_up;
  logic [PowerW-1:0]  pw_dn;
  logic               left_lead;
  logic               right_lead;
  state_t             nx;

  assign lc_ext     = {{(RcountW-LcountW){1'b0}}, req_i.left_count};
  assign left_lead  = lc_ext > req_i.right_count;
  assign diff       = left_lead ? (lc_ext - req_i.right_count) : (req_i.right_count - lc_ext);
  assign right_lead = (req_i.right_count > lc_ext) && (diff >= RightMinLead);
  assign delta      = cfg_i.step_gain * diff;
  assign sum        = {{(DeltaW-PowerW+1){1'b0}}, cfg_i.base_power} + {1'b0, delta};
  assign pw_up      = (sum > {{(DeltaW-PowerW+1){1'b0}}, PowerMax}) ? PowerMax
                                                                    : sum[PowerW-1:0];
  assign pw_dn      = (delta >= {{(DeltaW-PowerW){1'b0}}, cfg_i.base_power}) ? '0
                      : (cfg_i.base_power - delta[PowerW-1:0]);

  always_comb begin
    nx = state_i;
    if (req_i.command == CMD_START) begin
      nx.left_hold      = cfg_i.base_power;
      nx.right_hold     = cfg_i.base_power;
      nx.left_finished  = 1'b0;
      nx.right_finished = 1'b0;
      nx.left_ramp      = '0;
      nx.right_ramp     = '0;
      nx.active         = 1'b1;
    end else if (state_i.active) begin
      if (state_i.left_finished) begin
        if (state_i.left_ramp != '0) nx.left_ramp = state_i.left_ramp - 1'b1;
      end else if (lc_ext >= cfg_i.target_pulses) begin
        nx.left_finished = 1'b1;
        nx.left_ramp     = cfg_i.base_power;
      end
      if (state_i.right_finished) begin
        if (state_i.right_ramp != '0) nx.right_ramp = state_i.right_ramp - 1'b1;
      end else if (req_i.right_count >= cfg_i.target_pulses) begin
        nx.right_finished = 1'b1;
        nx.right_ramp     = cfg_i.base_power;
      end
      if (!nx.left_finished && !nx.right_finished) begin
        priority if (left_lead) begin
          nx.left_hold  = pw_dn;
          nx.right_hold = pw_up;
        end else if (right_lead) begin
          nx.left_hold  = pw_up;
          nx.right_hold = pw_dn;
        end
      end
      if (nx.left_finished && nx.right_finished && nx.left_ramp == '0 && nx.right_ramp == '0) begin
        nx.active = 1'b0;
      end
    end
  end

  assign state_o = nx;

  always_comb begin
    res_o.left_drive  = '0;
    res_o.right_drive = '0;
    if (nx.active) begin
      res_o.left_drive  = nx.left_finished ? nx.left_ramp : nx.left_hold;
      res_o.right_drive = nx.right_finished ? nx.right_ramp : nx.right_hold;
    end
    res_o.left_at_target  = nx.left_finished;
    res_o.right_at_target = nx.right_finished;
    res_o.moving          = nx.active;
    res_o.move_done       = !nx.active && nx.left_finished && nx.right_finished;
  end

endmodule

@@ sv/wheel_balance_drive_control.sv @@
// Top level of the wheel balance drive controller.
`timescale 1ns / 1ps
// Straight-line drive controller for two wheels.
// Requests enter on the s_axis channel: tuser carries the command (0 start a
// move, 1 encoder sample), tdata the left and right pulse counts. Every
// request yields exactly one result on the m_axis channel with both drive
// values and the at-target, moving and move-done flags.
// Target, base power and gain are set through the APB port at 0x0, 0x4 and
// 0x8; write them only while no request is in flight.
// A request is captured in an input register, and the state update plus the
// result are computed in one pass into the output register. One request is
// taken per cycle in sustained operation while the receiver does not stall.
// When the receiver stalls, the output register holds its result and the
// input register holds the next request; s_axis_tready drops once both are
// full. Reset empties both registers, clears the drive state and loads the
// register defaults (target 0, base power 100, gain 10).

module wheel_balance_drive_control
  import wbdc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [23:0]      s_axis_tdata,  // left_count[7:0], right_count[23:8]
  input  logic [0:0]       s_axis_tuser,  // command[0]
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // left_drive[7:0], right_drive[15:8],
                                          // left_at_target[16], right_at_target[17],
                                          // moving[18], move_done[19], zero[23:20]
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t   cfg;
  req_t   req_q;
  logic   in_valid_q;
  logic   out_valid_q;
  res_t   res_q;
  res_t   res_d;
  state_t state_q, state_d;
  logic   advance;

  wbdc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wbdc_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .req_i   (req_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      req_q.command     <= cmd_e'(s_axis_tuser[0]);
      req_q.left_count  <= s_axis_tdata[7:0];
      req_q.right_count <= s_axis_tdata[23:8];
    end
    if (advance) res_q <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, res_q.move_done, res_q.moving, res_q.right_at_target,
                          res_q.left_at_target, res_q.right_drive, res_q.left_drive};

endmodule
